// ----- design/bth_pkg.sv -----
package bth_pkg;

  localparam int HEAP_BYTES = 65536;
  localparam int WORDS      = HEAP_BYTES / 4;
  localparam int WAW        = $clog2(WORDS);
  localparam int WALK_LIMIT = HEAP_BYTES / 8 + 2;
  localparam int WLW        = $clog2(WALK_LIMIT + 1);

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ZERO   = 2'd1;
  localparam logic [1:0] ST_OOM    = 2'd2;
  localparam logic [1:0] ST_INITF  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_WALK_RD,
    S_WALK_CHK,
    S_GROW,
    S_GROW_TAGS,
    S_MRG_RD,
    S_MRG_WAIT,
    S_MRG_P,
    S_MRG_N,
    S_MRG_WR,
    S_PLACE_RD,
    S_PLACE_WAIT,
    S_PLACE_WR,
    S_FREE_RD,
    S_DONE
  } state_t;

  // datapath operations, one per controller step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_INIT_WR,
    OP_WALK_RD,
    OP_WALK_STEP,
    OP_GROW_CHK,
    OP_GROW_WR,
    OP_MRG_RD,
    OP_MRG_LATCH,
    OP_MRG_NRD,
    OP_MRG_NLATCH,
    OP_MRG_WR,
    OP_PLACE_RD,
    OP_PLACE_WR,
    OP_FREE_SET
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sub;
  } cmd_t;

  typedef struct packed {
    logic       sub_last;
    logic       walk_hit;
    logic       walk_end;
    logic       grow_fail;
    logic       merge_skip;
    logic       place_ok;
    logic       pre_ok;
    logic [1:0] pre_status;
  } stat_t;

endpackage

// ----- design/bth_datapath.sv -----
module bth_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [16:0]      cfg_data,
  input  logic [1:0]       mode,
  input  logic [16:0]      request_size,
  input  logic [15:0]      block_addr,
  input  bth_pkg::cmd_t    cmd,
  output bth_pkg::stat_t   stat,
  output logic [15:0]      payload_addr,
  output logic [1:0]       status
);
  import bth_pkg::*;

  logic [31:0] mem [WORDS];
  logic [31:0] rdata;
  logic [WAW-1:0] raddr, waddr;
  logic [31:0] wdata;
  logic        we;

  logic [16:0] chunk;
  logic [17:0] brk;
  logic [1:0]  md;
  logic [17:0] asize;
  logic [15:0] target;
  logic [17:0] p;
  logic [WLW-1:0] cnt;
  logic [17:0] bp, sz, gsz;
  logic [17:0] ptag_sz;
  logic        palloc;
  logic        grow_init;
  logic [17:0] req_ext;
  logic [17:0] gbytes;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  function automatic logic [WAW-1:0] widx(input logic [17:0] a);
    return a[WAW+1:2];
  endfunction

  logic [17:0] tsz;
  assign tsz = {rdata[17:3], 3'b000};

  // split when at least 8 bytes remain; otherwise the whole block is taken
  logic        split;
  logic [17:0] psz;
  assign split = sz >= asize + 18'd8;
  assign psz   = split ? asize : sz;

  assign req_ext = {1'b0, request_size} + 18'd15;
  assign gbytes  = grow_init ? {1'b0, chunk}
                 : ((asize > {1'b0, chunk}) ? asize : {1'b0, chunk});

  always_comb begin
    logic [17:0] g;
    g = {gbytes[17:2] + {15'd0, gbytes[2]}, 2'b00};
    gsz = g;
  end

  always_comb begin
    stat.sub_last   = cmd.sub == 2'd3;
    stat.walk_end   = (cnt == WLW'(WALK_LIMIT)) || (p >= brk) || (tsz == 18'd0);
    stat.walk_hit   = (md == MODE_ALLOC) ? (!rdata[0] && asize <= tsz)
                                         : (p == {2'b00, target});
    stat.grow_fail  = gsz == 18'd0 || brk > 18'(HEAP_BYTES)
                      || gsz > 18'(HEAP_BYTES) - brk;
    stat.merge_skip = palloc && rdata[0];
    stat.place_ok   = rdata[0];
    stat.pre_ok     = 1'b1;
    stat.pre_status = ST_OK;
    unique case (mode)
      MODE_ALLOC: begin
        if (request_size == 17'd0) begin
          stat.pre_ok = 1'b0; stat.pre_status = ST_ZERO;
        end else if (brk < 18'd16) begin
          stat.pre_ok = 1'b0; stat.pre_status = ST_OOM;
        end
      end
      MODE_FREE: stat.pre_ok = brk >= 18'd16 && block_addr != 16'd0;
      MODE_INIT: stat.pre_ok = 1'b1;
      default:   stat.pre_ok = 1'b0;
    endcase
  end

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    unique case (cmd.op)
      OP_INIT_WR: begin
        we = 1'b1; waddr = WAW'(cmd.sub);
        unique case (cmd.sub)
          2'd0: wdata = 32'd0;
          2'd1: wdata = 32'd9;
          2'd2: wdata = 32'd9;
          default: wdata = 32'd1;
        endcase
      end
      OP_WALK_RD:   raddr = widx(p - 18'd4);
      OP_GROW_WR: begin
        we = 1'b1;
        unique case (cmd.sub)
          2'd0: begin waddr = widx(bp - 18'd4); wdata = {14'd0, sz}; end
          2'd1: begin waddr = widx(bp + sz - 18'd8); wdata = {14'd0, sz}; end
          default: begin waddr = widx(bp + sz - 18'd4); wdata = 32'd1; end
        endcase
      end
      OP_MRG_RD:    raddr = widx(bp - 18'd8);
      OP_MRG_NRD:   raddr = widx(bp + sz - 18'd4);
      OP_MRG_WR: begin
        we = 1'b1;
        wdata = {14'd0, sz};
        waddr = cmd.sub[0] ? widx(bp + sz - 18'd8) : widx(bp - 18'd4);
      end
      OP_PLACE_RD:  raddr = widx(bp - 18'd4);
      OP_PLACE_WR: begin
        we = 1'b1;
        unique case (cmd.sub)
          2'd0: begin waddr = widx(bp - 18'd4); wdata = {14'd0, psz} | 32'd1; end
          2'd1: begin waddr = widx(bp + psz - 18'd8);
                      wdata = {14'd0, psz} | 32'd1; end
          2'd2: begin we = split; waddr = widx(bp + asize - 18'd4);
                      wdata = {14'd0, sz - asize}; end
          default: begin we = split; waddr = widx(bp + sz - 18'd8);
                         wdata = {14'd0, sz - asize}; end
        endcase
      end
      OP_FREE_SET: begin
        we = 1'b1; wdata = {14'd0, sz};
        waddr = cmd.sub[0] ? widx(bp + sz - 18'd8) : widx(bp - 18'd4);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brk <= '0;
      chunk <= 17'd4096;
    end else begin
      if (cfg_we) chunk <= cfg_data;
      unique case (cmd.op)
        OP_START: begin
          md <= mode; target <= block_addr;
          asize <= (request_size <= 17'd8) ? 18'd16 : {req_ext[17:3], 3'b000};
          p <= 18'd8; cnt <= '0;
          payload_addr <= '0;
          status <= stat.pre_status;
          grow_init <= mode == MODE_INIT;
          if (mode == MODE_INIT) brk <= 18'd16;
        end
        OP_WALK_STEP: begin
          p <= p + tsz; cnt <= cnt + WLW'(1);
          bp <= p; sz <= tsz;
        end
        OP_GROW_CHK: begin
          if (stat.grow_fail) status <= grow_init ? ST_INITF : ST_OOM;
          else begin
            bp <= brk; sz <= gsz; brk <= brk + gsz;
          end
        end
        OP_MRG_LATCH: begin
          palloc <= rdata[0]; ptag_sz <= tsz;
        end
        OP_MRG_NLATCH: begin
          if (!palloc) begin
            bp <= bp - ptag_sz;
            sz <= sz + ptag_sz + (rdata[0] ? 18'd0 : tsz);
          end else if (!rdata[0]) sz <= sz + tsz;
        end
        OP_PLACE_WR: if (cmd.sub == 2'd0) payload_addr <= bp[15:0];
        OP_PLACE_RD: ;
        default: ;
      endcase
    end
  end
endmodule

// ----- design/bth_ctrl.sv -----
module bth_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      mode,
  input  bth_pkg::stat_t  stat,
  output bth_pkg::cmd_t   cmd,
  output logic            busy,
  output logic            done
);
  import bth_pkg::*;

  state_t state, state_next;
  logic [1:0] sub, sub_next;
  logic [1:0] md, md_next;
  logic       is_grow, is_grow_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; sub <= '0; md <= '0; is_grow <= 1'b0;
    end else begin
      state <= state_next; sub <= sub_next; md <= md_next; is_grow <= is_grow_next;
    end
  end

  always_comb begin
    state_next = state; sub_next = sub; md_next = md; is_grow_next = is_grow;
    cmd.op = OP_NONE; cmd.sub = sub;
    busy = state != S_IDLE; done = 1'b0;
    unique case (state)
      S_IDLE: if (start) begin
        cmd.op = OP_START; md_next = mode; sub_next = '0;
        if (!stat.pre_ok) state_next = S_DONE;
        else if (mode == MODE_INIT) state_next = S_INIT;
        else state_next = S_WALK_RD;
      end
      S_INIT: begin
        cmd.op = OP_INIT_WR; sub_next = sub + 2'd1;
        if (stat.sub_last) begin state_next = S_GROW; sub_next = '0; end
      end
      S_WALK_RD: begin cmd.op = OP_WALK_RD; state_next = S_WALK_CHK; end
      S_WALK_CHK: begin
        if (stat.walk_end) state_next = (md == MODE_ALLOC) ? S_GROW : S_DONE;
        else begin
          cmd.op = OP_WALK_STEP;
          if (stat.walk_hit) begin
            if (md == MODE_ALLOC) state_next = S_PLACE_RD;
            else if (stat.place_ok) begin state_next = S_FREE_RD; sub_next = '0; end
            else state_next = S_DONE;
          end else state_next = S_WALK_RD;
        end
      end
      S_GROW: begin
        cmd.op = OP_GROW_CHK; sub_next = '0;
        state_next = stat.grow_fail ? S_DONE : S_GROW_TAGS;
      end
      S_GROW_TAGS: begin
        cmd.op = OP_GROW_WR; sub_next = sub + 2'd1;
        if (sub == 2'd2) begin state_next = S_MRG_RD; is_grow_next = 1'b1; end
      end
      S_FREE_RD: begin
        cmd.op = OP_FREE_SET; sub_next = sub + 2'd1;
        if (sub == 2'd1) begin state_next = S_MRG_RD; is_grow_next = 1'b0; end
      end
      S_MRG_RD:   begin cmd.op = OP_MRG_RD; state_next = S_MRG_WAIT; end
      S_MRG_WAIT: begin cmd.op = OP_MRG_LATCH; state_next = S_MRG_P; end
      S_MRG_P:    begin cmd.op = OP_MRG_NRD; state_next = S_MRG_N; end
      S_MRG_N: begin
        cmd.op = OP_MRG_NLATCH; sub_next = '0;
        state_next = stat.merge_skip ? S_MRG_WR : S_MRG_WR;
      end
      S_MRG_WR: begin
        cmd.op = OP_MRG_WR; sub_next = sub + 2'd1;
        if (sub == 2'd1)
          state_next = (is_grow && md == MODE_ALLOC) ? S_PLACE_RD : S_DONE;
      end
      S_PLACE_RD:   begin cmd.op = OP_PLACE_RD; state_next = S_PLACE_WAIT; end
      S_PLACE_WAIT: begin state_next = S_PLACE_WR; sub_next = '0; end
      S_PLACE_WR: begin
        cmd.op = OP_PLACE_WR; sub_next = sub + 2'd1;
        if (stat.sub_last) state_next = S_DONE;
      end
      S_DONE: begin done = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- design/boundary_tag_heap_allocator.sv -----
// channel  | signals                                   | handshake
// input    | mode, request_size, block_addr            | start & !busy
// result   | payload_addr, status                      | done, one cycle
// config   | grow_chunk_bytes                          | grow_chunk_we
// One word in flight. Init writes the initial tags and then grows the heap.
// Allocate and free walk the block list, one tag read per header from the heap
// memory's single read port; then allocate places the block on a fit or grows the
// heap first, and free marks a found block free and merges it with its neighbours.
// Reset sets the break to zero and the chunk register to 4096; heap memory is not cleared.
// The receiver cannot stall: done pulses one cycle with the result.
module boundary_tag_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [16:0] request_size,
  input  logic [15:0] block_addr,
  input  logic        grow_chunk_we,
  input  logic [16:0] grow_chunk_bytes,
  output logic        done,
  output logic [15:0] payload_addr,
  output logic [1:0]  status
);
  import bth_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bth_ctrl u_ctrl (
    .clk, .rst, .start, .mode, .stat, .cmd, .busy, .done
  );

  bth_datapath u_dp (
    .clk, .rst, .cfg_we(grow_chunk_we), .cfg_data(grow_chunk_bytes),
    .mode, .request_size, .block_addr, .cmd, .stat, .payload_addr, .status
  );
endmodule
